// ----- hdl/tcp_echo_connection_fsm_macros.svh -----
// Assertion macros for the TCP echo connection block.
// Used by the checker bound to the top level; no other dependencies.
`ifndef TCP_ECHO_CONNECTION_FSM_MACROS_SVH
`define TCP_ECHO_CONNECTION_FSM_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TCPE_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tcpe: implication check failed");

// Next-cycle implication, disabled while reset is asserted.
`define TCPE_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tcpe: next-cycle check failed");

`endif

// ----- hdl/tcpe_pkg.sv -----
// Shared types and constants of the TCP echo connection block.
// Used by tcpe_step, the top level and the checker; depends on nothing.
package tcpe_pkg;

  typedef enum logic [1:0] {
    ST_CLOSED   = 2'd0,
    ST_SYN_RCVD = 2'd1,
    ST_ESTAB    = 2'd2,
    ST_LAST_ACK = 2'd3
  } conn_state_e;

  // Flag bit positions in a segment's flags byte
  localparam int unsigned FLB_FIN = 0;
  localparam int unsigned FLB_SYN = 1;
  localparam int unsigned FLB_RST = 2;
  localparam int unsigned FLB_PSH = 3;
  localparam int unsigned FLB_ACK = 4;

  // Reply flag codes
  localparam logic [7:0] FL_FIN    = 8'h01;
  localparam logic [7:0] FL_RST    = 8'h04;
  localparam logic [7:0] FL_ACK    = 8'h10;
  localparam logic [7:0] FL_DATA   = 8'h18;
  localparam logic [7:0] FL_SYNACK = 8'h12;

  // Configuration register indexes
  localparam logic CFG_ECHO_PORT = 1'b0;
  localparam logic CFG_RX_WINDOW = 1'b1;

  localparam logic [15:0] ECHO_PORT_RST = 16'd7;
  localparam logic [15:0] RX_WINDOW_RST = 16'd8192;

  typedef struct packed {
    logic [15:0] peer_port;
    logic [15:0] local_port;
    logic [31:0] seq_num;
    logic [31:0] ack_num;
    logic [7:0]  seg_flags;
    logic [15:0] payload_length;
    logic [31:0] initial_seq;
  } seg_t;

  typedef struct packed {
    conn_state_e state;
    logic [31:0] rcv_next;
    logic [31:0] snd_next;
    logic [15:0] peer_port;
    logic [15:0] local_port;
  } conn_t;

  typedef struct packed {
    logic [7:0]  out_flags;
    logic [15:0] out_src_port;
    logic [15:0] out_dst_port;
    logic [31:0] out_seq;
    logic [31:0] out_ack;
    logic [15:0] out_window;
    logic [15:0] out_length;
    logic        last;
  } reply_t;

endpackage

// ----- hdl/tcpe_step.sv -----
// Per-segment connection update: next connection state and up to two replies.
// Pure combinational logic; depends on tcpe_pkg.
module tcpe_step (
  input  tcpe_pkg::seg_t         seg_i,
  input  tcpe_pkg::conn_t        conn_i,
  input  logic [15:0]            echo_port_i,
  input  logic [15:0]            rx_window_i,
  output tcpe_pkg::conn_t        conn_o,
  output logic [1:0]             n_rep_o,
  output tcpe_pkg::reply_t [1:0] rep_o
);
  import tcpe_pkg::*;

  logic        is_closed;
  logic        f_fin, f_syn, f_rst, f_psh, f_ack;
  logic        port_ok;
  logic        open_ok;
  logic        fin_go;
  logic        data_go;
  logic [31:0] rcv_fin;
  logic [31:0] rcv1;
  logic [31:0] rcv_data;
  logic [31:0] snd_plus1;
  logic [31:0] seq_plus1;
  conn_state_e state1;
  conn_state_e state2;

  assign is_closed = (conn_i.state == ST_CLOSED);
  assign f_fin     = seg_i.seg_flags[FLB_FIN];
  assign f_syn     = seg_i.seg_flags[FLB_SYN];
  assign f_rst     = seg_i.seg_flags[FLB_RST];
  assign f_psh     = seg_i.seg_flags[FLB_PSH];
  assign f_ack     = seg_i.seg_flags[FLB_ACK];
  assign port_ok   = (seg_i.local_port == echo_port_i);
  assign open_ok   = !is_closed && !f_rst;

  assign seq_plus1 = seg_i.seq_num + 32'd1;
  assign snd_plus1 = conn_i.snd_next + 32'd1;
  assign rcv_fin   = conn_i.rcv_next + 32'd1;

  // FIN only counts in established state
  assign fin_go = open_ok && f_fin && (conn_i.state == ST_ESTAB);
  assign rcv1   = fin_go ? rcv_fin : conn_i.rcv_next;
  assign state1 = fin_go ? ST_LAST_ACK : conn_i.state;

  // ACK handling on the state left by FIN
  always_comb begin
    state2 = state1;
    if (f_ack) begin
      unique case (state1)
        ST_SYN_RCVD: if (seg_i.ack_num == conn_i.snd_next) state2 = ST_ESTAB;
        ST_LAST_ACK: if (seg_i.ack_num == snd_plus1) state2 = ST_CLOSED;
        default: ;
      endcase
    end
  end

  assign data_go  = open_ok && f_psh && f_ack && (state2 == ST_ESTAB) &&
                    (seg_i.seq_num == rcv1);
  assign rcv_data = rcv1 + {16'd0, seg_i.payload_length};

  // Next connection state
  always_comb begin
    conn_o = conn_i;
    if (is_closed) begin
      conn_o.peer_port  = seg_i.peer_port;
      conn_o.local_port = seg_i.local_port;
      conn_o.rcv_next   = '0;
      conn_o.snd_next   = '0;
      if (f_syn && port_ok) begin
        conn_o.rcv_next = seq_plus1;
        conn_o.snd_next = seg_i.initial_seq + 32'd1;
        conn_o.state    = ST_SYN_RCVD;
      end
    end else if (f_rst) begin
      conn_o.state = ST_CLOSED;
    end else begin
      conn_o.state = state2;
      if (data_go) begin
        conn_o.rcv_next = rcv_data;
        conn_o.snd_next = conn_i.snd_next + {16'd0, seg_i.payload_length};
      end else begin
        conn_o.rcv_next = rcv1;
      end
    end
  end

  // Replies
  always_comb begin
    reply_t base;
    base              = '0;
    base.out_src_port = is_closed ? seg_i.local_port : conn_i.local_port;
    base.out_dst_port = is_closed ? seg_i.peer_port : conn_i.peer_port;
    base.out_window   = rx_window_i;
    base.out_seq      = conn_i.snd_next;
    rep_o             = {base, base};
    n_rep_o           = 2'd0;
    if (is_closed) begin
      if (f_syn) begin
        n_rep_o           = 2'd1;
        rep_o[0].last     = 1'b1;
        rep_o[0].out_flags = port_ok ? FL_SYNACK : FL_RST;
        rep_o[0].out_seq  = port_ok ? seg_i.initial_seq : 32'd0;
        rep_o[0].out_ack  = port_ok ? seq_plus1 : 32'd0;
      end
    end else if (fin_go) begin
      n_rep_o            = 2'd2;
      rep_o[0].out_flags = FL_ACK;
      rep_o[0].out_ack   = rcv_fin;
      rep_o[1].out_flags = FL_FIN;
      rep_o[1].out_ack   = rcv_fin;
      rep_o[1].last      = 1'b1;
    end else if (data_go) begin
      n_rep_o             = 2'd1;
      rep_o[0].out_flags  = FL_DATA;
      rep_o[0].out_ack    = rcv_data;
      rep_o[0].out_length = seg_i.payload_length;
      rep_o[0].last       = 1'b1;
    end
  end

endmodule

// ----- hdl/tcp_echo_connection_fsm.sv -----
// Top level of the TCP echo connection block: input register, connection
// registers, two-entry reply buffer. Depends on tcpe_pkg and tcpe_step.
//
//   channel   dir  handshake                  payload
//   s_axis    in   s_axis_tvalid/tready       tdata: segment fields, tuser: seg_flags
//   m_axis    out  m_axis_tvalid/tready       tdata: reply header, tuser: out_flags,
//                                             tlast: final reply of a segment
//   cfg       in   cfg_we_i (no handshake)    cfg_idx_i, cfg_data_i
//
// A segment is registered on accept and processed from that register; its
// replies go into the reply buffer registers, whose head drives m_axis. One
// segment per cycle is taken while the buffer has room; a FIN that yields two
// replies waits for an empty buffer, which drains one reply per cycle while
// m_axis_tready is high. Reset clears the connection to closed with zero counters
// and loads echo_port = 7, rx_window = 8192. A stalled m_axis holds its reply.
module tcp_echo_connection_fsm (
  input  logic         clk_i,
  input  logic         rst_ni,
  // Segment in. tdata from bit 0: peer_port[16], local_port[16], seq_num[32],
  // ack_num[32], payload_length[16], initial_seq[32]
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [143:0] s_axis_tdata,
  input  logic [7:0]   s_axis_tuser,   // seg_flags
  // Reply out. tdata from bit 0: out_src_port[16], out_dst_port[16],
  // out_seq[32], out_ack[32], out_window[16], out_length[16]
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [127:0] m_axis_tdata,
  output logic [7:0]   m_axis_tuser,   // out_flags
  output logic         m_axis_tlast,   // last
  // Configuration writes
  input  logic         cfg_we_i,
  input  logic         cfg_idx_i,
  input  logic [15:0]  cfg_data_i
);
  import tcpe_pkg::*;

  // Configuration registers
  logic [15:0] echo_port_q;
  logic [15:0] rx_window_q;

  // Input register
  logic  in_vld_q, in_vld_d;
  seg_t  seg_q, seg_d;

  // Connection state
  conn_t conn_q;
  conn_t conn_nxt;

  // Reply buffer: entry 0 is the head
  reply_t [1:0] buf_q, buf_d;
  logic [1:0]   cnt_q, cnt_d;

  logic             s_acc;
  logic             pop;
  logic             fire;
  logic [1:0]       cnt_left;
  logic [1:0]       space;
  logic [1:0]       n_rep;
  reply_t [1:0]     rep;

  tcpe_step u_step (
    .seg_i       (seg_q),
    .conn_i      (conn_q),
    .echo_port_i (echo_port_q),
    .rx_window_i (rx_window_q),
    .conn_o      (conn_nxt),
    .n_rep_o     (n_rep),
    .rep_o       (rep)
  );

  // Handshakes. A segment advances once its replies fit in the buffer after
  // this cycle's pop; segments without replies never wait.
  assign pop      = m_axis_tvalid && m_axis_tready;
  assign cnt_left = cnt_q - {1'b0, pop};
  assign space    = 2'd2 - cnt_left;
  assign fire     = in_vld_q && (n_rep <= space);
  assign s_axis_tready = !in_vld_q || fire;
  assign s_acc    = s_axis_tvalid && s_axis_tready;

  // Unpack the incoming item
  always_comb begin
    seg_d.peer_port      = s_axis_tdata[15:0];
    seg_d.local_port     = s_axis_tdata[31:16];
    seg_d.seq_num        = s_axis_tdata[63:32];
    seg_d.ack_num        = s_axis_tdata[95:64];
    seg_d.payload_length = s_axis_tdata[111:96];
    seg_d.initial_seq    = s_axis_tdata[143:112];
    seg_d.seg_flags      = s_axis_tuser;
  end

  always_comb begin
    in_vld_d = in_vld_q;
    if (s_acc) begin
      in_vld_d = 1'b1;
    end else if (fire) begin
      in_vld_d = 1'b0;
    end
  end

  // Reply buffer: shift on pop, then append this segment's replies
  always_comb begin
    buf_d = buf_q;
    if (pop) begin
      buf_d[0] = buf_q[1];
    end
    cnt_d = cnt_left;
    if (fire) begin
      if (n_rep == 2'd2) begin
        // Only reached with an empty buffer
        buf_d[0] = rep[0];
        buf_d[1] = rep[1];
      end else if (n_rep == 2'd1) begin
        buf_d[cnt_left[0]] = rep[0];
      end
      cnt_d = cnt_left + n_rep;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q    <= 1'b0;
      cnt_q       <= 2'd0;
      echo_port_q <= ECHO_PORT_RST;
      rx_window_q <= RX_WINDOW_RST;
      conn_q      <= '{state: ST_CLOSED, default: '0};
    end else begin
      in_vld_q <= in_vld_d;
      cnt_q    <= cnt_d;
      if (fire) begin
        conn_q <= conn_nxt;
      end
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_ECHO_PORT: echo_port_q <= cfg_data_i;
          CFG_RX_WINDOW: rx_window_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  // Payload registers: hold unless loaded
  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      seg_q <= seg_d;
    end
    buf_q <= buf_d;
  end

  // Drive the head reply
  assign m_axis_tvalid = (cnt_q != 2'd0);
  assign m_axis_tdata  = {buf_q[0].out_length, buf_q[0].out_window, buf_q[0].out_ack,
                          buf_q[0].out_seq, buf_q[0].out_dst_port, buf_q[0].out_src_port};
  assign m_axis_tuser  = buf_q[0].out_flags;
  assign m_axis_tlast  = buf_q[0].last;

endmodule

// ----- hdl/tcpe_checker.sv -----
// Port-level checks of the TCP echo connection block, bound to the top level.
// Depends on tcpe_pkg and tcp_echo_connection_fsm_macros.svh.
`include "tcp_echo_connection_fsm_macros.svh"

module tcpe_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [127:0] m_axis_tdata,
  input logic [7:0]   m_axis_tuser,
  input logic         m_axis_tlast
);
  import tcpe_pkg::*;

  // A stalled reply holds
  `TCPE_ASSERT_NXT(a_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast))

  // A refusal carries zero seq, ack and length and ends its segment
  `TCPE_ASSERT_IMP(a_rst_reply, clk_i, rst_ni, m_axis_tvalid && (m_axis_tuser == FL_RST), m_axis_tlast && (m_axis_tdata[95:32] == 64'd0) && (m_axis_tdata[127:112] == 16'd0))

  // The ACK of a FIN is never the last reply
  `TCPE_ASSERT_IMP(a_ack_not_last, clk_i, rst_ni, m_axis_tvalid && (m_axis_tuser == FL_ACK), !m_axis_tlast && (m_axis_tdata[127:112] == 16'd0))

  // The ACK of a FIN is followed at once by a FIN with the same numbers
  `TCPE_ASSERT_NXT(a_fin_follows, clk_i, rst_ni, m_axis_tvalid && m_axis_tready && (m_axis_tuser == FL_ACK), m_axis_tvalid && (m_axis_tuser == FL_FIN) && m_axis_tlast && $stable(m_axis_tdata[95:32]))

endmodule

bind tcp_echo_connection_fsm tcpe_checker u_tcpe_checker (.*);
